@@ rtl/core/lvrf_pkg.sv @@
`timescale 1ns / 1ps
package lvrf_pkg;

  localparam int TABLE_ENTRIES_DEF = 1024;
  localparam int KEY_BITS_DEF      = 64;
  localparam int MAX_PROBES_DEF    = 8;

  // home slot fits if the table has at most 65536 entries; the user must keep to this, it is not checked
  localparam int HOME_W = 16;

  localparam logic [63:0] HASH_MUL = 64'h9E3779B97F4A7C15;

  localparam logic [1:0] CMD_ROW   = 2'd0;
  localparam logic [1:0] CMD_BEAT  = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;
  localparam logic [1:0] CMD_END   = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] row_key;
    logic [63:0] row_version;
  } in_t;

  typedef struct packed {
    logic        keep;
    logic        new_key;
    logic        table_full;
    logic        backfill_active;
    logic [31:0] late_count;
  } out_t;

  typedef struct packed {
    in_t               item;
    logic [HOME_W-1:0] home;
  } qent_t;

endpackage

@@ rtl/core/latest_version_late_row_filter_core.sv @@
`timescale 1ns / 1ps
// channel   | handshake            | payload
// ----------+----------------------+-------------------------------------
// input     | push / full          | din  (cmd, row_key, row_version)
// result    | pop / empty          | dout (keep, new_key, table_full,
//           |                      |       backfill_active, late_count)
// config    | cfg_valid/cfg_ready  | cfg_data (backfill_unique)
//
// front: accept, then partial products, sum and queue push, in that order,
// with reciprocal estimate, multiply back, subtract and fix before the push
// when TABLE_ENTRIES is not a power of 2. back: markers are answered in idle,
// rows take a table read and an evaluation per probe (one table read port).
// after reset the table is cleared entry by entry with full high.
// queues between front and back and on the result side let each stall alone.
module latest_version_late_row_filter_core #(
  parameter int TABLE_ENTRIES = lvrf_pkg::TABLE_ENTRIES_DEF,
  parameter int KEY_BITS      = lvrf_pkg::KEY_BITS_DEF,
  parameter int MAX_PROBES    = lvrf_pkg::MAX_PROBES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  lvrf_pkg::in_t  din,
  input  logic           pop,
  output logic           empty,
  output lvrf_pkg::out_t dout,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_data
);
  import lvrf_pkg::*;

  logic  clearing;
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  qent_t q_din;
  qent_t q_dout;
  logic  o_push;
  logic  o_full;
  out_t  o_din;

  lvrf_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .KEY_BITS(KEY_BITS)
  ) u_front (
    .clk(clk), .rst(rst), .push(push), .din(din), .full(full),
    .hold(clearing), .q_push(q_push), .q_din(q_din), .q_full(q_full)
  );

  lvrf_fifo #(.WIDTH($bits(qent_t))) u_queue (
    .clk(clk), .rst(rst), .push(q_push), .din(q_din), .full(q_full),
    .pop(q_pop), .dout(q_dout), .empty(q_empty)
  );

  lvrf_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .KEY_BITS(KEY_BITS),
    .MAX_PROBES(MAX_PROBES)
  ) u_back (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data), .clearing(clearing), .q_empty(q_empty),
    .q_dout(q_dout), .q_pop(q_pop), .o_full(o_full), .o_push(o_push),
    .o_din(o_din)
  );

  lvrf_fifo #(.WIDTH($bits(out_t))) u_result (
    .clk(clk), .rst(rst), .push(o_push), .din(o_din), .full(o_full),
    .pop(pop), .dout(dout), .empty(empty)
  );
endmodule

@@ rtl/core/lvrf_fifo.sv @@
`timescale 1ns / 1ps
module lvrf_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  logic [WIDTH-1:0] slots [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign dout    = slots[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (do_pop) rptr <= ~rptr;
      if (do_push && !do_pop) count <= count + 2'd1;
      else if (do_pop && !do_push) count <= count - 2'd1;
    end
  end
endmodule

@@ rtl/core/lvrf_front.sv @@
`timescale 1ns / 1ps
module lvrf_front #(
  parameter int TABLE_ENTRIES = lvrf_pkg::TABLE_ENTRIES_DEF,
  parameter int KEY_BITS      = lvrf_pkg::KEY_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  lvrf_pkg::in_t  din,
  output logic           full,
  input  logic           hold,
  output logic           q_push,
  output lvrf_pkg::qent_t q_din,
  input  logic           q_full
);
  import lvrf_pkg::*;

  localparam int  RW   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam bit  POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);
  localparam logic [31:0] NMOD  = 32'(TABLE_ENTRIES);
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / TABLE_ENTRIES);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_MUL  = 3'd1;
  localparam logic [2:0] F_SUM  = 3'd2;
  localparam logic [2:0] F_RCP  = 3'd3;
  localparam logic [2:0] F_QN   = 3'd4;
  localparam logic [2:0] F_SUB  = 3'd5;
  localparam logic [2:0] F_FIX  = 3'd6;
  localparam logic [2:0] F_PUSH = 3'd7;

  logic [2:0]    state;
  in_t           item;
  logic [63:0]   p0;
  logic [31:0]   p1;
  logic [31:0]   p2;
  logic [31:0]   h;
  logic [31:0]   qn;
  logic [31:0]   rr;
  logic [RW-1:0] r;
  logic [63:0]   key_m;

  assign full  = (state != F_IDLE) || hold;
  assign key_m = 64'(din.row_key[KEY_BITS-1:0]);

  assign q_push     = (state == F_PUSH);
  assign q_din.item = item;
  assign q_din.home = POW2 ? HOME_W'(h[RW-1:0]) : HOME_W'(r);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (push && !full) begin
            item.cmd         <= din.cmd;
            item.row_key     <= key_m;
            item.row_version <= din.row_version;
            state            <= F_MUL;
          end
        end
        F_MUL: begin
          // low 64 bits of the product from three 32x32 partial products
          p0    <= 64'(item.row_key[31:0]) * 64'(HASH_MUL[31:0]);
          p1    <= 32'(item.row_key[63:32] * HASH_MUL[31:0]);
          p2    <= 32'(item.row_key[31:0] * HASH_MUL[63:32]);
          state <= F_SUM;
        end
        F_SUM: begin
          h     <= p0[63:32] + p1 + p2;
          state <= POW2 ? F_PUSH : F_RCP;
        end
        F_RCP: begin
          // quotient estimate by reciprocal, low by at most one
          p0    <= 64'(h) * 64'(RECIP);
          state <= F_QN;
        end
        F_QN: begin
          qn    <= p0[63:32] * NMOD;
          state <= F_SUB;
        end
        F_SUB: begin
          rr    <= h - qn;
          state <= F_FIX;
        end
        F_FIX: begin
          if (rr >= NMOD) r <= RW'(rr - NMOD);
          else r <= RW'(rr);
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/core/lvrf_back.sv @@
`timescale 1ns / 1ps
module lvrf_back #(
  parameter int TABLE_ENTRIES = lvrf_pkg::TABLE_ENTRIES_DEF,
  parameter int KEY_BITS      = lvrf_pkg::KEY_BITS_DEF,
  parameter int MAX_PROBES    = lvrf_pkg::MAX_PROBES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_data,
  output logic            clearing,
  input  logic            q_empty,
  input  lvrf_pkg::qent_t q_dout,
  output logic            q_pop,
  input  logic            o_full,
  output logic            o_push,
  output lvrf_pkg::out_t  o_din
);
  import lvrf_pkg::*;

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int PW = $clog2(MAX_PROBES + 1);
  localparam int EW = 1 + KEY_BITS + 64;
  localparam logic [AW-1:0] LAST = AW'(TABLE_ENTRIES - 1);

  localparam logic [1:0] B_CLR  = 2'd0;
  localparam logic [1:0] B_IDLE = 2'd1;
  localparam logic [1:0] B_RD   = 2'd2;
  localparam logic [1:0] B_EV   = 2'd3;

  logic [EW-1:0] mem [TABLE_ENTRIES];
  logic [EW-1:0] rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  logic [1:0]    state;
  qent_t         cur;
  logic [AW-1:0] slot;
  logic [PW-1:0] probe;
  logic [AW-1:0] clr_addr;
  logic          started;
  logic          done;
  logic          started_next;
  logic          done_next;
  logic [31:0]   late;
  logic [31:0]   late_next;
  logic          bf_unique;

  logic                e_valid;
  logic [KEY_BITS-1:0] e_key;
  logic [63:0]         e_ver;
  logic [KEY_BITS-1:0] c_key;
  logic                hit;

  assign cfg_ready = 1'b1;
  assign clearing  = (state == B_CLR);

  assign e_valid = rd_data[EW-1];
  assign e_key   = rd_data[EW-2 -: KEY_BITS];
  assign e_ver   = rd_data[63:0];
  assign c_key   = cur.item.row_key[KEY_BITS-1:0];
  assign hit     = e_valid && (e_key == c_key);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[slot];
  end

  always_comb begin
    wr_en        = 1'b0;
    wr_addr      = slot;
    wr_data      = {1'b1, c_key, cur.item.row_version};
    q_pop        = 1'b0;
    o_push       = 1'b0;
    started_next = started;
    done_next    = done;
    late_next    = late;
    o_din.keep       = 1'b0;
    o_din.new_key    = 1'b0;
    o_din.table_full = 1'b0;
    case (state)
      B_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
      end
      B_IDLE: begin
        if (!q_empty && !o_full) begin
          q_pop = 1'b1;
          if (q_dout.item.cmd == CMD_START) begin
            if (!done) started_next = 1'b1;
            o_push = 1'b1;
          end else if (q_dout.item.cmd == CMD_END) begin
            if (!done && started) done_next = 1'b1;
            o_push = 1'b1;
          end else if (q_dout.item.cmd == CMD_BEAT) begin
            o_push = 1'b1;
          end
        end
      end
      B_EV: begin
        if (!e_valid) begin
          wr_en         = 1'b1;
          o_push        = 1'b1;
          o_din.keep    = 1'b1;
          o_din.new_key = 1'b1;
        end else if (hit) begin
          o_push     = 1'b1;
          o_din.keep = 1'b1;
          if ((bf_unique && started && !done) || (cur.item.row_version > e_ver)) begin
            wr_en = 1'b1;
          end else if (cur.item.row_version < e_ver) begin
            o_din.keep = 1'b0;
            if (late != 32'hFFFF_FFFF) late_next = late + 32'd1;
          end
        end else if (probe == PW'(MAX_PROBES - 1)) begin
          o_push           = 1'b1;
          o_din.keep       = 1'b1;
          o_din.table_full = 1'b1;
        end
      end
      default: ;
    endcase
    o_din.backfill_active = bf_unique && started_next && !done_next;
    o_din.late_count      = late_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLR;
      clr_addr  <= '0;
      slot      <= '0;
      probe     <= '0;
      started   <= 1'b0;
      done      <= 1'b0;
      late      <= '0;
      bf_unique <= 1'b0;
    end else begin
      if (cfg_valid) bf_unique <= cfg_data;
      started <= started_next;
      done    <= done_next;
      late    <= late_next;
      case (state)
        B_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST) state <= B_IDLE;
        end
        B_IDLE: begin
          if (!q_empty && !o_full) begin
            cur <= q_dout;
            if (q_dout.item.cmd == CMD_ROW) begin
              slot  <= q_dout.home[AW-1:0];
              probe <= '0;
              state <= B_RD;
            end
          end
        end
        B_RD: state <= B_EV;
        B_EV: begin
          if (o_push) begin
            state <= B_IDLE;
          end else begin
            // linear probe with wrap
            probe <= probe + PW'(1);
            slot  <= (slot == LAST) ? '0 : slot + AW'(1);
            state <= B_RD;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end
endmodule
